/* rtl/grt_pkg.sv */
// ----------------------------------------------------------------------------
// grt_pkg
// Shared types and constants of the grid ray traversal block.
// ----------------------------------------------------------------------------
package grt_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS    = 12;
   localparam int DIR_ONE_BITS = 14;
   localparam int DIST_W       = 23;
   localparam int POS_W        = 22;
   localparam int DIR_W        = 16;
   localparam int CELL_W       = 14;
   localparam int QUO_W        = DIR_ONE_BITS + FRAC_BITS + 1;
   localparam int CNT_W        = $clog2(QUO_W);

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
   localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};

   // Request kinds
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   // Reflection sign codes
   localparam logic [1:0] REF_NONE = 2'b00;
   localparam logic [1:0] REF_POS  = 2'b01;
   localparam logic [1:0] REF_NEG  = 2'b11;

   typedef logic [DIST_W-1:0]        dist_type;
   typedef logic signed [CELL_W-1:0] cell_type;

endpackage

/* rtl/grt_recip.sv */
// ----------------------------------------------------------------------------
// grt_recip
// Per-axis step lengths: floor(2^26 / |d|) for two axes at once, one quotient
// bit per cycle, saturated to the distance range.
// ----------------------------------------------------------------------------
module grt_recip
   import grt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIR_W-1:0] abs_x,
   input  logic [DIR_W-1:0] abs_y,
   output logic             done,
   output dist_type         step_x,
   output dist_type         step_y
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIR_W-1:0] ax_ff, ay_ff;
   logic [DIR_W:0]   rx_ff, ry_ff;
   logic [QUO_W-1:0] qx_ff, qy_ff;
   logic             dbit;
   logic [DIR_W:0]   tx, ty;

   // Dividend is a single one at its top bit
   assign dbit = (cnt_ff == CNT_W'(QUO_W - 1));
   assign tx   = {rx_ff[DIR_W-1:0], dbit};
   assign ty   = {ry_ff[DIR_W-1:0], dbit};

   // Restoring division, both axes in step
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W - 1);
            ax_ff   <= abs_x;
            ay_ff   <= abs_y;
            rx_ff   <= '0;
            ry_ff   <= '0;
            qx_ff   <= '0;
            qy_ff   <= '0;
         end else if (busy_ff) begin
            if (tx >= {1'b0, ax_ff}) begin
               rx_ff <= tx - {1'b0, ax_ff};
               qx_ff <= {qx_ff[QUO_W-2:0], 1'b1};
            end else begin
               rx_ff <= tx;
               qx_ff <= {qx_ff[QUO_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, ay_ff}) begin
               ry_ff <= ty - {1'b0, ay_ff};
               qy_ff <= {qy_ff[QUO_W-2:0], 1'b1};
            end else begin
               ry_ff <= ty;
               qy_ff <= {qy_ff[QUO_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // Saturate to the distance range (a zero divisor gives all ones)
   assign done   = done_ff;
   assign step_x = (qx_ff > QUO_W'(DIST_MAX)) ? DIST_MAX : qx_ff[DIST_W-1:0];
   assign step_y = (qy_ff > QUO_W'(DIST_MAX)) ? DIST_MAX : qy_ff[DIST_W-1:0];

endmodule

/* rtl/grid_ray_traversal.sv */
// ----------------------------------------------------------------------------
// grid_ray_traversal
// Tile map with solid and edge flags and a grid-stepping ray caster.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_*. A write request (req_tuser = 0) sets the two
//   flags of one tile and produces no response. A cast
//   request (req_tuser = 1) walks a ray and produces one response on rsp_*,
//   with rsp_tuser = hit.
//   A cast runs in order: the step reciprocals (quotient bits, then the load),
//   the first crossings, a corner tile pair read if the ray starts on a grid
//   corner heading down-left, a tile map read and a check per tile crossed,
//   on a hit the hit position (multiply, add, corner test) and another corner
//   tile pair read if the hit is on a grid corner, and the load of the
//   response register. The single tile map read port sets the per-tile cost.
//   One request is worked on at a time. A finished response waits in the
//   output register while the next request is accepted; a cast that
//   finishes while that register is still full waits until it drains.
//   After reset the tile map is swept to open, one tile per cycle;
//   req_tready stays low until then.
// ----------------------------------------------------------------------------
module grid_ray_traversal
   import grt_pkg::*;
#(
   parameter int MAP_TILES = 1024
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tile_x[9:0], tile_y[19:10], tile_solid[20], tile_edge[21],
   // barrier_mode[22], origin_x[44:23], origin_y[66:45], dir_x[82:67],
   // dir_y[98:83], length_limit[121:99], zero fill[127:122]
   input  logic [127:0] req_tdata,
   // command[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance[22:0], hit_x[44:23], hit_y[66:45], reflect_x[68:67],
   // reflect_y[70:69], zero fill[71]
   output logic [71:0]  rsp_tdata,
   // hit[0]
   output logic         rsp_tuser
);

   localparam int TW     = $clog2(MAP_TILES);
   localparam int DEPTH  = MAP_TILES * MAP_TILES;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIV, S_LINE, S_PAIR0, S_PAIR1, S_PAIR2,
      S_STEP, S_EVAL, S_HMUL, S_HADD, S_REFL, S_DONE
   } state_type;

   state_type   state_ff;
   logic [1:0]  mem [DEPTH];
   logic [1:0]  rd_data_ff;
   logic        inmap_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   // Request fields
   logic [9:0]        f_tile_x, f_tile_y;
   cell_type          wr_x, wr_y;
   logic              wr_ok;

   // Cast context
   logic              bit_ff;
   logic [POS_W-1:0]  ox_ff, oy_ff;
   logic signed [DIR_W-1:0] dx_ff, dy_ff;
   dist_type          maxlen_ff;
   dist_type          sx_ff, sy_ff, lx_ff, ly_ff, dist_ff;
   cell_type          cx_ff, cy_ff;
   logic              cornered_ff, found_ff, reflect_ff;
   logic [1:0]        rx_ff, ry_ff;
   cell_type          ax_ff, ay_ff, bx_ff, by_ff;
   logic              a_solid_ff;
   logic signed [DIR_W+DIST_W:0] prodx_ff, prody_ff;
   logic [POS_W-1:0]  hx_ff, hy_ff;

   // Response register
   logic              rsp_valid_ff, rsp_hit_ff;
   logic [71:0]       rsp_data_ff;
   logic              rsp_load;

   // Divider hookup
   logic              div_start, div_done;
   logic [DIR_W-1:0]  abs_x, abs_y;
   dist_type          step_x, step_y;

   // Read port and step logic
   cell_type          rd_x, rd_y, nx, ny;
   logic              step_on_x;
   logic              req_fire;
   logic [FRAC_BITS-1:0] fx, fy;
   logic [FRAC_BITS:0]   wx, wy;
   logic [FRAC_BITS+DIST_W:0] linx, liny;
   logic [DIST_W:0]   lx_next, ly_next;
   logic signed [POS_W+5:0] sumx, sumy;

   function automatic logic in_map(cell_type x, cell_type y);
      return !x[CELL_W-1] && !y[CELL_W-1] &&
             (x < CELL_W'(MAP_TILES)) && (y < CELL_W'(MAP_TILES));
   endfunction

   function automatic logic [ADDR_W-1:0] tile_addr(cell_type x, cell_type y);
      return ADDR_W'(ADDR_W'(y[TW-1:0]) * ADDR_W'(MAP_TILES) + ADDR_W'(x[TW-1:0]));
   endfunction

   function automatic logic [POS_W-1:0] clamp_pos(logic signed [POS_W+5:0] v);
      if (v < 0) return '0;
      if (v > $signed({6'd0, POS_MAX})) return POS_MAX;
      return v[POS_W-1:0];
   endfunction

   assign f_tile_x   = req_tdata[9:0];
   assign f_tile_y   = req_tdata[19:10];
   assign wr_x       = cell_type'({4'd0, f_tile_x});
   assign wr_y       = cell_type'({4'd0, f_tile_y});
   assign wr_ok      = in_map(wr_x, wr_y);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Reciprocal unit
   assign div_start = req_fire && (req_tuser == CMD_CAST);
   assign abs_x = req_tdata[82] ? DIR_W'(-req_tdata[82:67]) : req_tdata[82:67];
   assign abs_y = req_tdata[98] ? DIR_W'(-req_tdata[98:83]) : req_tdata[98:83];

   grt_recip u_recip (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .abs_x  (abs_x),
      .abs_y  (abs_y),
      .done   (div_done),
      .step_x (step_x),
      .step_y (step_y)
   );

   // First crossings
   assign fx   = ox_ff[FRAC_BITS-1:0];
   assign fy   = oy_ff[FRAC_BITS-1:0];
   assign wx   = dx_ff[DIR_W-1] ? {1'b0, fx} : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fx};
   assign wy   = dy_ff[DIR_W-1] ? {1'b0, fy} : (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, fy};
   assign linx = wx * sx_ff;
   assign liny = wy * sy_ff;

   // Next crossing along the walk
   assign step_on_x = lx_ff < ly_ff;
   assign nx = step_on_x ? (dx_ff[DIR_W-1] ? cx_ff - 1'b1 : cx_ff + 1'b1) : cx_ff;
   assign ny = step_on_x ? cy_ff : (dy_ff[DIR_W-1] ? cy_ff - 1'b1 : cy_ff + 1'b1);
   assign lx_next = {1'b0, lx_ff} + {1'b0, sx_ff};
   assign ly_next = {1'b0, ly_ff} + {1'b0, sy_ff};

   // Hit position sums (arithmetic shift floors negative products)
   assign sumx = $signed({6'd0, ox_ff}) + (POS_W+6)'(prodx_ff >>> DIR_ONE_BITS);
   assign sumy = $signed({6'd0, oy_ff}) + (POS_W+6)'(prody_ff >>> DIR_ONE_BITS);

   // Response register loads when the cast is done and the slot is free
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // Read address select
   always_comb begin
      unique case (state_ff)
         S_PAIR0: begin rd_x = ax_ff; rd_y = ay_ff; end
         S_PAIR1: begin rd_x = bx_ff; rd_y = by_ff; end
         default: begin rd_x = nx;    rd_y = ny;    end
      endcase
   end

   // Tile map: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         mem[clr_cnt_ff] <= 2'b00;
      end else if (req_fire && (req_tuser == CMD_WRITE) && wr_ok) begin
         mem[tile_addr(wr_x, wr_y)] <= {req_tdata[21], req_tdata[20]};
      end
      rd_data_ff <= mem[tile_addr(rd_x, rd_y)];
      inmap_ff   <= in_map(rd_x, rd_y);
   end

   // Control sequence and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_fire && (req_tuser == CMD_CAST)) begin
                  bit_ff      <= req_tdata[22];
                  ox_ff       <= req_tdata[44:23];
                  oy_ff       <= req_tdata[66:45];
                  dx_ff       <= req_tdata[82:67];
                  dy_ff       <= req_tdata[98:83];
                  maxlen_ff   <= req_tdata[121:99];
                  cx_ff       <= cell_type'({4'd0, req_tdata[44:35]});
                  cy_ff       <= cell_type'({4'd0, req_tdata[66:57]});
                  found_ff    <= 1'b0;
                  cornered_ff <= 1'b0;
                  dist_ff     <= '0;
                  rx_ff       <= REF_NONE;
                  ry_ff       <= REF_NONE;
                  state_ff    <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  sx_ff    <= step_x;
                  sy_ff    <= step_y;
                  state_ff <= S_LINE;
               end
            end
            S_LINE: begin
               lx_ff <= (linx[FRAC_BITS+DIST_W:FRAC_BITS] > (DIST_W+1)'(DIST_MAX)) ?
                        DIST_MAX : linx[FRAC_BITS+DIST_W-1:FRAC_BITS];
               ly_ff <= (liny[FRAC_BITS+DIST_W:FRAC_BITS] > (DIST_W+1)'(DIST_MAX)) ?
                        DIST_MAX : liny[FRAC_BITS+DIST_W-1:FRAC_BITS];
               if (fx == '0 && fy == '0 && sx_ff == sy_ff &&
                   dx_ff[DIR_W-1] && dy_ff[DIR_W-1]) begin
                  // start on a grid corner heading down-left
                  ax_ff      <= cx_ff - 1'b1;
                  ay_ff      <= cy_ff;
                  bx_ff      <= cx_ff;
                  by_ff      <= cy_ff - 1'b1;
                  reflect_ff <= 1'b0;
                  state_ff   <= S_PAIR0;
               end else begin
                  state_ff <= (maxlen_ff == '0) ? S_DONE : S_STEP;
               end
            end
            S_PAIR0: state_ff <= S_PAIR1;
            S_PAIR1: begin
               a_solid_ff <= rd_data_ff[0] && inmap_ff;
               state_ff   <= S_PAIR2;
            end
            S_PAIR2: begin
               if (reflect_ff) begin
                  if (a_solid_ff && rd_data_ff[0] && inmap_ff) begin
                     rx_ff <= REF_NEG;
                     ry_ff <= REF_NEG;
                  end
                  state_ff <= S_DONE;
               end else begin
                  cornered_ff <= a_solid_ff && rd_data_ff[0] && inmap_ff;
                  state_ff    <= (maxlen_ff == '0) ? S_DONE : S_STEP;
               end
            end
            S_STEP: begin
               cx_ff <= nx;
               cy_ff <= ny;
               if (step_on_x) begin
                  dist_ff <= lx_ff;
                  lx_ff   <= lx_next[DIST_W] ? DIST_MAX : lx_next[DIST_W-1:0];
                  rx_ff   <= REF_NEG;
                  ry_ff   <= REF_POS;
               end else begin
                  dist_ff <= ly_ff;
                  ly_ff   <= ly_next[DIST_W] ? DIST_MAX : ly_next[DIST_W-1:0];
                  rx_ff   <= REF_POS;
                  ry_ff   <= REF_NEG;
               end
               state_ff <= S_EVAL;
            end
            S_EVAL: begin
               if (rd_data_ff[bit_ff] && inmap_ff && !(cornered_ff && dist_ff == '0)) begin
                  found_ff <= 1'b1;
                  state_ff <= S_HMUL;
               end else if (dist_ff >= maxlen_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_HMUL: begin
               prodx_ff <= dx_ff * $signed({1'b0, dist_ff});
               prody_ff <= dy_ff * $signed({1'b0, dist_ff});
               state_ff <= S_HADD;
            end
            S_HADD: begin
               hx_ff    <= clamp_pos(sumx);
               hy_ff    <= clamp_pos(sumy);
               state_ff <= S_REFL;
            end
            S_REFL: begin
               // Hit on a grid corner: test the tile pair for a corner bounce
               if (hx_ff[FRAC_BITS-1:0] == '0 && hy_ff[FRAC_BITS-1:0] == '0 &&
                   dx_ff != '0 && dy_ff != '0) begin
                  reflect_ff <= 1'b1;
                  ax_ff      <= cell_type'({4'd0, hx_ff[POS_W-1:FRAC_BITS]}) - 1'b1;
                  bx_ff      <= cell_type'({4'd0, hx_ff[POS_W-1:FRAC_BITS]});
                  if (dx_ff[DIR_W-1] == dy_ff[DIR_W-1]) begin
                     ay_ff <= cell_type'({4'd0, hy_ff[POS_W-1:FRAC_BITS]});
                     by_ff <= cell_type'({4'd0, hy_ff[POS_W-1:FRAC_BITS]}) - 1'b1;
                  end else begin
                     ay_ff <= cell_type'({4'd0, hy_ff[POS_W-1:FRAC_BITS]}) - 1'b1;
                     by_ff <= cell_type'({4'd0, hy_ff[POS_W-1:FRAC_BITS]});
                  end
                  state_ff <= S_PAIR0;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_hit_ff <= found_ff;
                  if (found_ff) begin
                     rsp_data_ff <= {1'b0, ry_ff, rx_ff, hy_ff, hx_ff, dist_ff};
                  end else begin
                     rsp_data_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule

/* rtl/grt_checker.sv */
// ----------------------------------------------------------------------------
// grt_checker
// Port-level checks of the grid ray traversal block, bound to its top level.
// ----------------------------------------------------------------------------
module grt_checker
   import grt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Map sweep follows reset: no requests taken, no response pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("requests taken or response pending right after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // A miss reports all zeros
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss response carries nonzero fields");

   // A hit always carries real reflection signs
   a_hit_reflect: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[68:67] == REF_POS || rsp_tdata[68:67] == REF_NEG) &&
         (rsp_tdata[70:69] == REF_POS || rsp_tdata[70:69] == REF_NEG))
      else $error("hit response with bad reflection sign");

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (.*);
